[hw/rtl/dtcn_pkg.sv]
// Package for the decimal to Chinese numeral token reader.
// Shared sizes, token codes and the controller/datapath command and status types.
// No dependencies.
package dtcn_pkg;

  // Number of decimal places read out (1 to 9)
  localparam int DIGITS = 9;

  // Input and output field widths
  localparam int VALUE_W = 30;
  localparam int TOKEN_W = 4;

  // Largest value that fits; larger inputs saturate to it
  localparam int LIMIT = 10 ** DIGITS - 1;

  // BCD register and digit position widths
  localparam int BCD_W = 4 * DIGITS;
  localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // Double dabble takes two input bits per cycle
  localparam int CONV_STEPS = VALUE_W / 2;
  localparam int CNT_W = (CONV_STEPS > 1) ? $clog2(CONV_STEPS) : 1;

  // Token codes
  localparam logic [TOKEN_W-1:0] TOK_ZERO = 4'd0;
  localparam logic [TOKEN_W-1:0] TOK_TEN  = 4'd10;
  localparam logic [TOKEN_W-1:0] TOK_WAN  = 4'd13;
  localparam logic [TOKEN_W-1:0] TOK_YI   = 4'd14;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture and saturate the input, reset the readout state
    logic conv;       // one double dabble step (two bits)
    logic emit_step;  // one readout step
    logic emit_zero;  // emit the single zero token
  } dtcn_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic conv_last;  // this conversion step is the final one
    logic all_zero;   // converted number is zero
    logic emit_done;  // this readout step finishes the number
  } dtcn_sts_t;

endpackage

[hw/rtl/decimal_to_chinese_numeral_tokens.sv]
// Chinese numeral token reader, top level: controller plus datapath.
// Steps: accept, then double dabble conversion (two bits per cycle), then a single readout step
// for zero, else one readout step per digit place plus one per extra token at a place;
// each token shows in the cycle after its readout step.
// A new number is accepted only once the last one has been read out. Tokens cannot be stalled.
// Synchronous reset returns to idle with no strobe pending.
module decimal_to_chinese_numeral_tokens
  import dtcn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output logic               busy,
  output logic               strobe,
  output logic [TOKEN_W-1:0] token,
  output logic               last
);

  dtcn_cmd_t cmd;
  dtcn_sts_t sts;

  dtcn_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dtcn_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .value  (value),
    .cmd    (cmd),
    .sts    (sts),
    .strobe (strobe),
    .token  (token),
    .last   (last)
  );

  // Tokens only come out of a transaction in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("token strobe without a transaction in progress");

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // The final token is not followed directly by another token
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("token strobe right after the final token");

  // Token codes stay within the defined set
  a_token_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (token <= TOK_YI))
    else $error("token code out of range");

endmodule

[hw/rtl/dtcn_ctrl.sv]
// Controller for the Chinese numeral token reader.
// Sequences capture, binary to BCD conversion and token readout.
// Depends on dtcn_pkg.
module dtcn_ctrl
  import dtcn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dtcn_sts_t  sts,
  output dtcn_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        if (sts.conv_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.all_zero) begin
          cmd.emit_zero = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.emit_step = 1'b1;
          if (sts.emit_done) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and registered busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

[hw/rtl/dtcn_datapath.sv]
// Datapath for the Chinese numeral token reader.
// Saturation, two-bit-per-cycle double dabble, and the token readout sequencer.
// Depends on dtcn_pkg.
module dtcn_datapath
  import dtcn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [VALUE_W-1:0] value,
  input  dtcn_cmd_t          cmd,
  output dtcn_sts_t          sts,
  output logic               strobe,
  output logic [TOKEN_W-1:0] token,
  output logic               last
);

  // Slots within one digit place, in emission order
  localparam logic [1:0] SLOT_ZERO  = 2'd0;
  localparam logic [1:0] SLOT_GLYPH = 2'd1;
  localparam logic [1:0] SLOT_UNIT  = 2'd2;
  localparam logic [1:0] SLOT_WAN   = 2'd3;

  localparam logic [VALUE_W-1:0] LIMIT_V = VALUE_W'(LIMIT);

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [CNT_W-1:0]   cnt;
  logic [POS_W-1:0]   pos;
  logic [1:0]         slot;
  logic               zp;
  logic               started;

  // Add 3 to every BCD digit of 5 or more
  function automatic logic [BCD_W-1:0] dd_add3(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < DIGITS; i++) begin
      if (b[i*4 +: 4] >= 4'd5) begin
        r[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  // Two double dabble steps
  logic [BCD_W-1:0] bcd_a;
  logic [BCD_W-1:0] bcd_b;
  always_comb begin
    bcd_a = dd_add3(bcd);
    bcd_a = {bcd_a[BCD_W-2:0], bin[VALUE_W-1]};
    bcd_b = dd_add3(bcd_a);
    bcd_b = {bcd_b[BCD_W-2:0], bin[VALUE_W-2]};
  end

  // Current digit and place facts
  logic [3:0] d;
  logic [3:0] pos4;
  logic       nz;
  logic       grp_nz;
  logic       below_nz;
  always_comb begin
    d        = bcd[pos*4 +: 4];
    pos4     = 4'(pos);
    nz       = (d != 4'd0);
    grp_nz   = 1'b0;
    below_nz = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (i >= 4 && i <= 7 && bcd[i*4 +: 4] != 4'd0) begin
        grp_nz = 1'b1;
      end
      if (4'(i) < pos4 && bcd[i*4 +: 4] != 4'd0) begin
        below_nz = 1'b1;
      end
    end
  end

  // Which slots this place produces, and the first one still due
  logic [3:0]         present;
  logic [3:0]         avail;
  logic               any_avail;
  logic [1:0]         first;
  logic               more_here;
  logic               later_any;
  logic [TOKEN_W-1:0] tok_sel;
  always_comb begin
    present[SLOT_ZERO]  = nz && zp;
    present[SLOT_GLYPH] = nz;
    present[SLOT_UNIT]  = nz && ((DIGITS == 9 && pos4 == 4'd8) || pos4[1:0] != 2'd0);
    present[SLOT_WAN]   = (DIGITS >= 5) && pos4 == 4'd4 && grp_nz;

    for (int j = 0; j < 4; j++) begin
      avail[j] = present[j] && (2'(j) >= slot);
    end
    any_avail = |avail;

    first = SLOT_WAN;
    for (int j = 3; j >= 0; j--) begin
      if (avail[j]) begin
        first = 2'(j);
      end
    end

    more_here = 1'b0;
    for (int j = 0; j < 4; j++) begin
      if (present[j] && any_avail && 2'(j) > first) begin
        more_here = 1'b1;
      end
    end

    // Tokens still to come from lower places
    later_any = below_nz || ((DIGITS >= 5) && pos4 > 4'd4 && grp_nz);

    unique case (first)
      SLOT_ZERO:  tok_sel = TOK_ZERO;
      SLOT_GLYPH: tok_sel = d;
      SLOT_UNIT:  tok_sel = (pos4 == 4'd8) ? TOK_YI
                                           : TOK_TEN + {2'b00, pos4[1:0]} - 4'd1;
      SLOT_WAN:   tok_sel = TOK_WAN;
      default:    tok_sel = TOK_ZERO;
    endcase
  end

  logic advance;
  assign advance = !more_here;

  // Status to the controller
  always_comb begin
    sts.conv_last = (cnt == CNT_W'(CONV_STEPS - 1));
    sts.all_zero  = (bcd == '0);
    sts.emit_done = (pos == '0) && advance;
  end

  // Conversion and readout registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin     <= (value > LIMIT_V) ? LIMIT_V : value;
      bcd     <= '0;
      cnt     <= '0;
      pos     <= POS_W'(DIGITS - 1);
      slot    <= SLOT_ZERO;
      zp      <= 1'b0;
      started <= 1'b0;
    end else if (cmd.conv) begin
      bin <= {bin[VALUE_W-3:0], 2'b00};
      bcd <= bcd_b;
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.emit_step) begin
      if (any_avail) begin
        started <= 1'b1;
      end
      if (advance) begin
        pos  <= pos - POS_W'(1);
        slot <= SLOT_ZERO;
        if (nz) begin
          zp <= 1'b0;
        end else if (started) begin
          zp <= 1'b1;
        end
      end else begin
        slot <= first + 2'd1;
      end
    end
  end

  // Output register: one token per strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_zero || (cmd.emit_step && any_avail);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_zero) begin
      token <= TOK_ZERO;
      last  <= 1'b1;
    end else begin
      token <= tok_sel;
      last  <= !more_here && !later_any;
    end
  end

endmodule

[dv/decimal_to_chinese_numeral_tokens_tb.sv]
// Self-checking testbench for the Chinese numeral token reader.
// Drives numbers through the start/busy command handshake and checks every token strobe.
// Depends on dtcn_pkg and decimal_to_chinese_numeral_tokens.
`timescale 1ns / 100ps

module decimal_to_chinese_numeral_tokens_tb;
  import dtcn_pkg::*;

  localparam int WATCHDOG_CYCLES = 1000;
  localparam int RANDOM_NUMBERS = 155;
  localparam int CALM_TAIL = 30;     // last random numbers go back to back
  localparam int DRAIN_CYCLES = 45;  // longest readout plus margin
  localparam int NUM_DIRECTED = 25;

  // One expected token of a reading
  typedef struct packed {
    logic [TOKEN_W-1:0] tok;
    logic               fin;
  } reading_tok_t;

  // Directed row: ntok == 0 means the predictor supplies the reading,
  // otherwise toks holds ntok tokens, first token in the leftmost nibble used
  typedef struct packed {
    logic [VALUE_W-1:0] num;
    logic [4:0]         ntok;
    logic [67:0]        toks;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{30'd0,          5'd1,  68'h0},
    '{30'd1,          5'd1,  68'h1},
    '{30'd9,          5'd1,  68'h9},
    '{30'd10,         5'd2,  68'h1A},
    '{30'd10000,      5'd2,  68'h1D},
    '{30'd100000000,  5'd2,  68'h1E},
    '{30'd999999999,  5'd17, 68'h9E9C9B9A9D9C9B9A9},
    '{30'd1000000000, 5'd17, 68'h9E9C9B9A9D9C9B9A9},
    '{30'h3FFFFFFF,   5'd17, 68'h9E9C9B9A9D9C9B9A9},
    '{30'd11,         5'd0,  68'h0},
    '{30'd101,        5'd0,  68'h0},
    '{30'd110,        5'd0,  68'h0},
    '{30'd1001,       5'd0,  68'h0},
    '{30'd10010,      5'd0,  68'h0},
    '{30'd1000000,    5'd0,  68'h0},
    '{30'd10000010,   5'd0,  68'h0},
    '{30'd20000305,   5'd0,  68'h0},
    '{30'd100010000,  5'd0,  68'h0},
    '{30'd100000001,  5'd0,  68'h0},
    '{30'd500005000,  5'd0,  68'h0},
    '{30'd123456789,  5'd0,  68'h0},
    '{30'd987654321,  5'd0,  68'h0},
    '{30'h2AAAAAAA,   5'd0,  68'h0},
    '{30'h15555555,   5'd0,  68'h0},
    '{30'd90090009,   5'd0,  68'h0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               busy;
  logic               strobe;
  logic [TOKEN_W-1:0] token;
  logic               last;

  reading_tok_t pending_tokens[$];
  int mismatches = 0;
  int tokens_checked = 0;
  int numbers_sent = 0;
  int saturated_sent = 0;
  int idle_cycles = 0;

  decimal_to_chinese_numeral_tokens u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .value  (value),
    .busy   (busy),
    .strobe (strobe),
    .token  (token),
    .last   (last)
  );

  always #10 clk = ~clk;

  // Reading predictor: queues the tokens one number produces
  function automatic void predict_reading(input logic [VALUE_W-1:0] num);
    logic [3:0]      dig [DIGITS];
    longint unsigned rem;
    int              produced;
    bit              zero_run;
    bit              wan_group;
    rem = 64'(num);
    produced = 0;
    zero_run = 1'b0;
    wan_group = 1'b0;
    if (rem > 64'(LIMIT)) rem = 64'(LIMIT);
    for (int i = 0; i < DIGITS; i++) begin
      dig[i] = 4'(rem % 10);
      rem = rem / 10;
    end
    for (int i = DIGITS - 1; i >= 0; i--) begin
      if (dig[i] == 4'd0) begin
        // leading zeros never open a zero run
        if (produced > 0) zero_run = 1'b1;
      end else begin
        if (zero_run) begin
          pending_tokens.push_back('{TOK_ZERO, 1'b0});
          produced++;
          zero_run = 1'b0;
        end
        pending_tokens.push_back('{dig[i], 1'b0});
        produced++;
        if (i == 8) begin
          pending_tokens.push_back('{TOK_YI, 1'b0});
          produced++;
        end else if ((i & 3) != 0) begin
          pending_tokens.push_back('{TOK_TEN + TOKEN_W'((i & 3) - 1), 1'b0});
          produced++;
        end
        if (i >= 4 && i <= 7) wan_group = 1'b1;
      end
      // ten-thousand unit closes a nonzero group; a pending zero survives it
      if (i == 4 && wan_group) begin
        pending_tokens.push_back('{TOK_WAN, 1'b0});
        produced++;
        wan_group = 1'b0;
      end
    end
    if (produced == 0) pending_tokens.push_back('{TOK_ZERO, 1'b0});
    pending_tokens[pending_tokens.size() - 1].fin = 1'b1;
  endfunction

  // Random number: mostly digit built with a random zero density, some raw 30-bit, some small (0 to 20)
  function automatic logic [VALUE_W-1:0] random_number();
    longint unsigned acc;
    logic [31:0]     raw;
    int              mode;
    int              places;
    int              zero_odds;
    mode = $urandom_range(0, 9);
    raw = $urandom;
    if (mode == 0) return raw[VALUE_W-1:0];
    if (mode == 1) return VALUE_W'($urandom_range(0, 20));
    places = $urandom_range(1, DIGITS);
    zero_odds = $urandom_range(0, 3);
    acc = 0;
    for (int i = 0; i < places; i++) begin
      if ($urandom_range(0, 3) < zero_odds) acc = acc * 10;
      else acc = acc * 10 + $urandom_range(1, 9);
    end
    return acc[VALUE_W-1:0];
  endfunction

  // Present one number and hold it until the transaction is accepted
  task automatic send_number(input logic [VALUE_W-1:0] num, input int ntok,
                             input logic [67:0] toks);
    start <= 1'b1;
    value <= num;
    do @(posedge clk); while (busy !== 1'b0);
    if (ntok == 0) begin
      predict_reading(num);
    end else begin
      for (int k = 0; k < ntok; k++)
        pending_tokens.push_back('{toks[4*(ntok-1-k) +: 4], k == ntok - 1});
    end
    numbers_sent++;
    if (num > LIMIT) saturated_sent++;
  endtask

  // Random idle burst on the command side
  task automatic maybe_pause(input bit allow);
    logic [31:0] noise;
    if (allow && $urandom_range(0, 2) == 0) begin
      noise = $urandom;
      start <= 1'b0;
      value <= noise[VALUE_W-1:0];
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every queued token
  task automatic drain_tokens();
    start <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
  endtask

  // Token checker and watchdog
  always @(posedge clk) begin : token_check
    reading_tok_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (strobe) begin
        if (pending_tokens.size() == 0) begin
          $error("unexpected token %0d last %0b with no reading pending", token, last);
          mismatches++;
        end else begin
          want = pending_tokens.pop_front();
          tokens_checked++;
          if (token !== want.tok) begin
            $error("token: expected %0d, got %0d", want.tok, token);
            mismatches++;
          end
          if (last !== want.fin) begin
            $error("last: expected %0b, got %0b", want.fin, last);
            mismatches++;
          end
        end
      end
      if (strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_CYCLES) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_number(DIRECTED_ROWS[r].num, int'(DIRECTED_ROWS[r].ntok),
                  DIRECTED_ROWS[r].toks);
      maybe_pause(1'b1);
    end
    drain_tokens();

    // random numbers, one full drain midway, no idling at the tail
    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      send_number(random_number(), 0, 68'h0);
      if (n == RANDOM_NUMBERS / 2) drain_tokens();
      else maybe_pause(n < RANDOM_NUMBERS - CALM_TAIL);
    end
    drain_tokens();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Read out %0d numbers (%0d directed, %0d above the nine-digit limit)",
             numbers_sent, NUM_DIRECTED, saturated_sent);
    $display("Checked %0d tokens, %0d mismatches", tokens_checked, mismatches);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/dtcn_pkg.sv
hw/rtl/dtcn_ctrl.sv
hw/rtl/dtcn_datapath.sv
hw/rtl/decimal_to_chinese_numeral_tokens.sv
dv/decimal_to_chinese_numeral_tokens_tb.sv
